// ===== src/vgcs_pkg.sv =====
// Shared types and constants for the voxel grid conditional store.
package vgcs_pkg;

  // Fixed widths of the item fields and configuration registers
  localparam int COORD_W    = 8;
  localparam int SIZE_W     = 6;
  localparam int VALUE_W    = 16;
  localparam int COUNT_OUT_W = 16;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Linear index before the range check: x + y*sx + z*sx*sy with sizes below 64
  localparam int IDX_SUM_W  = 24;
  // Product widths in the index pipeline
  localparam int COORD_SUM_W = COORD_W + 1;
  localparam int SXSY_W     = 2 * SIZE_W;
  localparam int YX_W       = 16;
  localparam int ZXY_W      = 22;
  localparam int TOTAL_W    = 3 * SIZE_W;

  localparam int QUEUE_DEPTH = 2;

  // Register indexes (byte address divided by four)
  localparam logic [2:0] REG_OFFSET_X = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z = 3'd2;
  localparam logic [2:0] REG_SIZE_X   = 3'd3;
  localparam logic [2:0] REG_SIZE_Y   = 3'd4;
  localparam logic [2:0] REG_SIZE_Z   = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  typedef enum logic [1:0] {
    MODE_CLEAR     = 2'd0,
    MODE_WRITE_NEG = 2'd1,
    MODE_WRITE_POS = 2'd2,
    MODE_READ      = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic signed [COORD_W-1:0] offset_z;
    logic [SIZE_W-1:0]         size_x;
    logic [SIZE_W-1:0]         size_y;
    logic [SIZE_W-1:0]         size_z;
  } cfg_t;

  // One classified access handed from the front end to the store
  typedef struct packed {
    mode_e                     mode;
    logic                      oor;
    logic [IDX_SUM_W-1:0]      idx;
    logic signed [VALUE_W-1:0] nv;
  } task_t;

endpackage

// ===== src/voxel_grid_conditional_store_top.sv =====
// Top level of the voxel grid conditional store: register port, front end, queue, store.
//
//  channel  direction  handshake                      payload
//  -------  ---------  -----------------------------  ------------------------------------------
//  in       to block   in_valid_i / in_stall_o        mode_i, coord_x/y/z_i, new_value_i
//  out      from block out_valid_o / out_stall_i      read_value_o, above_zero_count_o,
//                                                     written_o, out_of_range_o
//  cfg      to block   psel, penable, pwrite, pready  paddr (reg index * 4), pwdata, prdata
//
//  Cycles: the front end takes a transfer each cycle while its two-stage index pipeline
//  and the two-entry queue have room. The store port sets the rate: a read or conditional
//  write passes through IDLE and then ACCESS (registered read, then write-back), an out-of-range access
//  only through IDLE, and a clear through IDLE and then a CLEAR sweep, one memory word a cycle.
//  Reset: the store is swept to -1.0 after reset, all MAX_DIM**3 words (32768 by default);
//  in_stall_o stays high meanwhile, register writes are taken as ever.
//  Stalls: out_stall_i holds the result register and backs up the queue, then the front end.
module voxel_grid_conditional_store_top #(
  parameter int MAX_DIM     = 32,
  parameter int SCALAR_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [vgcs_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [vgcs_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [vgcs_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready,
  // access channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             mode_i,
  input  logic signed [vgcs_pkg::COORD_W-1:0]    coord_x_i,
  input  logic signed [vgcs_pkg::COORD_W-1:0]    coord_y_i,
  input  logic signed [vgcs_pkg::COORD_W-1:0]    coord_z_i,
  input  logic signed [vgcs_pkg::VALUE_W-1:0]    new_value_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [vgcs_pkg::VALUE_W-1:0]    read_value_o,
  output logic [vgcs_pkg::COUNT_OUT_W-1:0]       above_zero_count_o,
  output logic                                   written_o,
  output logic                                   out_of_range_o
);
  import vgcs_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  logic  in_ready, init_done;
  logic  q_push, q_full, q_pop, q_valid;
  task_t q_in, q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register write: only the low bits of each register are kept
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_OFFSET_X: cfg_d.offset_x = $signed(pwdata[COORD_W-1:0]);
        REG_OFFSET_Y: cfg_d.offset_y = $signed(pwdata[COORD_W-1:0]);
        REG_OFFSET_Z: cfg_d.offset_z = $signed(pwdata[COORD_W-1:0]);
        REG_SIZE_X:   cfg_d.size_x   = pwdata[SIZE_W-1:0];
        REG_SIZE_Y:   cfg_d.size_y   = pwdata[SIZE_W-1:0];
        REG_SIZE_Z:   cfg_d.size_z   = pwdata[SIZE_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  // read-back, zero-extended raw register bits
  always_comb begin
    case (reg_idx)
      REG_OFFSET_X: prdata = CFG_DATA_W'($unsigned(cfg_q.offset_x));
      REG_OFFSET_Y: prdata = CFG_DATA_W'($unsigned(cfg_q.offset_y));
      REG_OFFSET_Z: prdata = CFG_DATA_W'($unsigned(cfg_q.offset_z));
      REG_SIZE_X:   prdata = CFG_DATA_W'(cfg_q.size_x);
      REG_SIZE_Y:   prdata = CFG_DATA_W'(cfg_q.size_y);
      REG_SIZE_Z:   prdata = CFG_DATA_W'(cfg_q.size_z);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset_x <= '0;
      cfg_q.offset_y <= '0;
      cfg_q.offset_z <= '0;
      cfg_q.size_x   <= SIZE_RESET;
      cfg_q.size_y   <= SIZE_RESET;
      cfg_q.size_z   <= SIZE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = !in_ready;

  // index computation and range check
  vgcs_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (init_done),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .mode_i      (mode_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .coord_z_i   (coord_z_i),
    .new_value_i (new_value_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .task_o      (q_in)
  );

  // decouples front end from the store
  vgcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  // voxel memory, counter and result register
  vgcs_back #(
    .MAX_DIM     (MAX_DIM),
    .SCALAR_BITS (SCALAR_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .task_valid_i       (q_valid),
    .task_i             (q_out),
    .task_pop_o         (q_pop),
    .init_done_o        (init_done),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_value_o       (read_value_o),
    .above_zero_count_o (above_zero_count_o),
    .written_o          (written_o),
    .out_of_range_o     (out_of_range_o)
  );

endmodule

// ===== src/vgcs_front.sv =====
// Front end: offset, linear index and range classification of each access.
module vgcs_front #(
  parameter int MAX_DIM = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             enable_i,
  input  vgcs_pkg::cfg_t                   cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       mode_i,
  input  logic signed [vgcs_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [vgcs_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [vgcs_pkg::COORD_W-1:0] coord_z_i,
  input  logic signed [vgcs_pkg::VALUE_W-1:0] new_value_i,
  input  logic                             full_i,
  output logic                             push_o,
  output vgcs_pkg::task_t                  task_o
);
  import vgcs_pkg::*;

  logic [SIZE_W-1:0] sx_eff, sy_eff, sz_eff;

  // stage 1: offset coordinates, sx*sy
  logic                          s1_v_q, s1_v_d;
  logic [1:0]                    s1_mode_q;
  logic signed [COORD_SUM_W-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic signed [COORD_SUM_W-1:0] x_d, y_d, z_d;
  logic signed [VALUE_W-1:0]     s1_nv_q;
  logic [SXSY_W-1:0]             s1_sxsy_q, sxsy_d;

  // stage 2: partial products and grid volume
  logic                          s2_v_q, s2_v_d;
  logic [1:0]                    s2_mode_q;
  logic signed [COORD_SUM_W-1:0] s2_x_q;
  logic signed [YX_W-1:0]        s2_yx_q, yx_d;
  logic signed [ZXY_W-1:0]       s2_zxy_q, zxy_d;
  logic [TOTAL_W-1:0]            s2_total_q, total_d;
  logic signed [VALUE_W-1:0]     s2_nv_q;

  logic signed [SIZE_W:0]        sx_s;
  logic signed [SXSY_W:0]        sxsy_s;
  logic signed [IDX_SUM_W-1:0]   idx_sum;
  logic                          accept, s1_to_s2, s2_adv;

  // sizes beyond the store saturate
  assign sx_eff = (32'(cfg_i.size_x) > MAX_DIM) ? SIZE_W'(MAX_DIM) : cfg_i.size_x;
  assign sy_eff = (32'(cfg_i.size_y) > MAX_DIM) ? SIZE_W'(MAX_DIM) : cfg_i.size_y;
  assign sz_eff = (32'(cfg_i.size_z) > MAX_DIM) ? SIZE_W'(MAX_DIM) : cfg_i.size_z;

  assign x_d    = COORD_SUM_W'(coord_x_i) + COORD_SUM_W'(cfg_i.offset_x);
  assign y_d    = COORD_SUM_W'(coord_y_i) + COORD_SUM_W'(cfg_i.offset_y);
  assign z_d    = COORD_SUM_W'(coord_z_i) + COORD_SUM_W'(cfg_i.offset_z);
  assign sxsy_d = SXSY_W'(sx_eff) * SXSY_W'(sy_eff);

  assign sx_s    = $signed({1'b0, sx_eff});
  assign sxsy_s  = $signed({1'b0, s1_sxsy_q});
  assign yx_d    = YX_W'(s1_y_q) * YX_W'(sx_s);
  assign zxy_d   = ZXY_W'(s1_z_q) * ZXY_W'(sxsy_s);
  assign total_d = TOTAL_W'(s1_sxsy_q) * TOTAL_W'(sz_eff);

  assign idx_sum = IDX_SUM_W'(s2_x_q) + IDX_SUM_W'(s2_yx_q) + IDX_SUM_W'(s2_zxy_q);

  assign push_o     = s2_v_q && !full_i;
  assign s2_adv     = !s2_v_q || !full_i;
  assign s1_to_s2   = s1_v_q && s2_adv;
  assign in_ready_o = enable_i && (!s1_v_q || s2_adv);
  assign accept     = in_valid_i && in_ready_o;

  // a negative index reads as huge unsigned, so one compare covers both ends
  always_comb begin
    task_o.mode = mode_e'(s2_mode_q);
    task_o.oor  = $unsigned(idx_sum) >= IDX_SUM_W'(s2_total_q);
    task_o.idx  = $unsigned(idx_sum);
    task_o.nv   = s2_nv_q;
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (accept) begin
      s1_v_d = 1'b1;
    end else if (s1_to_s2) begin
      s1_v_d = 1'b0;
    end
    s2_v_d = s2_v_q;
    if (s1_to_s2) begin
      s2_v_d = 1'b1;
    end else if (push_o) begin
      s2_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q <= mode_i;
      s1_x_q    <= x_d;
      s1_y_q    <= y_d;
      s1_z_q    <= z_d;
      s1_nv_q   <= new_value_i;
      s1_sxsy_q <= sxsy_d;
    end
    if (s1_to_s2) begin
      s2_mode_q  <= s1_mode_q;
      s2_x_q     <= s1_x_q;
      s2_yx_q    <= yx_d;
      s2_zxy_q   <= zxy_d;
      s2_total_q <= total_d;
      s2_nv_q    <= s1_nv_q;
    end
  end

endmodule

// ===== src/vgcs_queue.sv =====
// Short queue of classified accesses between front end and store.
module vgcs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vgcs_pkg::task_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vgcs_pkg::task_t data_o
);
  import vgcs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  task_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/vgcs_back.sv =====
// Back end: voxel memory, conditional read-modify-write, counter and result register.
module vgcs_back #(
  parameter int MAX_DIM     = 32,
  parameter int SCALAR_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                task_valid_i,
  input  vgcs_pkg::task_t                     task_i,
  output logic                                task_pop_o,
  output logic                                init_done_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [vgcs_pkg::VALUE_W-1:0] read_value_o,
  output logic [vgcs_pkg::COUNT_OUT_W-1:0]    above_zero_count_o,
  output logic                                written_o,
  output logic                                out_of_range_o
);
  import vgcs_pkg::*;

  localparam int DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int EXT_W   = CNT_W + COUNT_OUT_W;
  localparam int MINUS_ONE_I = -(2 ** (SCALAR_BITS - 4));
  localparam logic [SCALAR_BITS-1:0] MINUS_ONE = SCALAR_BITS'(MINUS_ONE_I);

  localparam logic [1:0] ST_INIT   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;
  localparam logic [1:0] ST_CLEAR  = 2'd3;

  logic [SCALAR_BITS-1:0] mem [DEPTH];
  logic [SCALAR_BITS-1:0] rdata_q;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  logic [SCALAR_BITS-1:0] mem_wdata;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  task_t             cur_q, cur_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [VALUE_W-1:0] rv_q, rv_d;
  logic [COUNT_OUT_W-1:0]    azc_q, azc_d;
  logic                      wr_q, wr_d, oor_q, oor_d;

  logic                          out_free, sweep_last, hit;
  logic signed [SCALAR_BITS-1:0] old_s, nv_s;
  logic signed [31:0]            old_ext;
  logic [EXT_W-1:0]              cnt_ext;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign sweep_last  = (ptr_q == ADDR_W'(DEPTH - 1));
  assign old_s       = $signed(rdata_q);
  assign nv_s        = SCALAR_BITS'(cur_q.nv);
  assign old_ext     = 32'(old_s);
  assign cnt_ext     = EXT_W'(cnt_d);
  assign hit         = ((cur_q.mode == MODE_WRITE_NEG) && (old_s < 0)) ||
                       ((cur_q.mode == MODE_WRITE_POS) && (old_s > 0));
  assign init_done_o = (state_q != ST_INIT);

  assign out_valid_o        = out_valid_q;
  assign read_value_o       = rv_q;
  assign above_zero_count_o = azc_q;
  assign written_o          = wr_q;
  assign out_of_range_o     = oor_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    task_pop_o  = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = ptr_q;
    mem_wdata   = MINUS_ONE;
    out_valid_d = out_valid_q && out_stall_i;
    rv_d        = rv_q;
    azc_d       = azc_q;
    wr_d        = wr_q;
    oor_d       = oor_q;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we = 1'b1;
        if (sweep_last) begin
          ptr_d = '0;
          cnt_d = '0;
          state_d = ST_IDLE;
          if (state_q == ST_CLEAR) begin
            out_valid_d = 1'b1;
            rv_d  = '0;
            azc_d = '0;
            wr_d  = 1'b0;
            oor_d = 1'b0;
          end
        end else begin
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        // only take work once the result register is sure to be free
        if (task_valid_i && out_free) begin
          task_pop_o = 1'b1;
          cur_d      = task_i;
          mem_addr   = task_i.idx[ADDR_W-1:0];
          if (task_i.mode == MODE_CLEAR) begin
            ptr_d   = '0;
            state_d = ST_CLEAR;
          end else if (task_i.oor) begin
            out_valid_d = 1'b1;
            rv_d  = '0;
            azc_d = cnt_ext[COUNT_OUT_W-1:0];
            wr_d  = 1'b0;
            oor_d = 1'b1;
          end else begin
            state_d = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        mem_addr  = cur_q.idx[ADDR_W-1:0];
        mem_wdata = nv_s;
        if (hit) begin
          mem_we = 1'b1;
          if ((nv_s > 0) && (old_s <= 0)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else if ((nv_s <= 0) && (old_s > 0)) begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        out_valid_d = 1'b1;
        rv_d  = old_ext[VALUE_W-1:0];
        azc_d = cnt_ext[COUNT_OUT_W-1:0];
        wr_d  = hit;
        oor_d = 1'b0;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // single-port store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    rv_q  <= rv_d;
    azc_q <= azc_d;
    wr_q  <= wr_d;
    oor_q <= oor_d;
  end

endmodule

// ===== test/voxel_grid_conditional_store_top_tb.sv =====
// Self-checking testbench for the voxel grid conditional store top level.
module voxel_grid_conditional_store_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vgcs_pkg::*;

  // Reset sweep plus at most a dozen clears, each walking the whole store, with slack
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int GRID_DEPTH     = 32768;
  localparam int GRID_DIM       = 32;
  localparam int MINUS_ONE_Q12  = -4096;
  localparam int N_SETTINGS     = 9;
  localparam int ITEMS_PER_SET  = 210;
  localparam int ITEMS_EMPTY    = 50;
  localparam int SETTLE_CYCLES  = 8;

  // One access as it travels over the input channel
  typedef struct packed {
    mode_e                     mode;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic signed [VALUE_W-1:0] nv;
  } access_t;

  // One result transfer
  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_OUT_W-1:0]    above_count;
    logic                      written;
    logic                      oor;
  } access_result_t;

  // Register settings walked through after the directed part:
  // plain small cube, extreme offsets on a single voxel, odd shape, extreme offsets on the
  // full cube, sizes above the maximum (saturate), an empty grid, a flat slab, a shifted cube
  // and one with random offsets on a small grid
  int set_ox [N_SETTINGS] = '{0, -128,  3,  127,  0, -7, 0, -1, 0};
  int set_oy [N_SETTINGS] = '{0,  127, -2, -128,  0, 12, 0, -1, 0};
  int set_oz [N_SETTINGS] = '{0, -128,  1,  127,  0, -3, 0, -1, 0};
  int set_sx [N_SETTINGS] = '{4,    1,  2,   32, 63,  0, 8,  3, 5};
  int set_sy [N_SETTINGS] = '{4,    1,  3,   32, 40,  5, 1,  3, 6};
  int set_sz [N_SETTINGS] = '{4,    1,  5,   32, 33,  5, 2,  3, 4};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Register port
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Access channel
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  access_t on_bus = '0;
  logic [1:0]                mode_i;
  logic signed [COORD_W-1:0] coord_x_i;
  logic signed [COORD_W-1:0] coord_y_i;
  logic signed [COORD_W-1:0] coord_z_i;
  logic signed [VALUE_W-1:0] new_value_i;

  // Result channel
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0] read_value_o;
  logic [COUNT_OUT_W-1:0]    above_zero_count_o;
  logic                      written_o;
  logic                      out_of_range_o;

  // Predictor state: its own copy of the grid, counter and registers
  logic signed [VALUE_W-1:0] grid_model [GRID_DEPTH];
  int                        above_zero_model;
  cfg_t                      cfg_model;

  access_t        pending_accesses [$];
  access_result_t expected_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int clears_left = 8;
  int mismatches = 0;
  int cycles = 0;
  int n_results = 0;
  int n_written = 0;
  int n_oor = 0;

  assign mode_i      = on_bus.mode;
  assign coord_x_i   = on_bus.cx;
  assign coord_y_i   = on_bus.cy;
  assign coord_z_i   = on_bus.cz;
  assign new_value_i = on_bus.nv;

  voxel_grid_conditional_store_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .coord_x_i          (coord_x_i),
    .coord_y_i          (coord_y_i),
    .coord_z_i          (coord_z_i),
    .new_value_i        (new_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_value_o       (read_value_o),
    .above_zero_count_o (above_zero_count_o),
    .written_o          (written_o),
    .out_of_range_o     (out_of_range_o)
  );

  always #1 clk_i = ~clk_i;

  // Sizes above the maximum extent saturate; zero gives an empty grid
  function automatic int grid_extent(logic [SIZE_W-1:0] s);
    return (int'(s) > GRID_DIM) ? GRID_DIM : int'(s);
  endfunction

  function automatic void clear_grid_model();
    for (int i = 0; i < GRID_DEPTH; i++) grid_model[i] = VALUE_W'(MINUS_ONE_Q12);
    above_zero_model = 0;
  endfunction

  // Works out the result of one accepted access and updates the predictor state
  function automatic access_result_t predict_access(access_t a);
    access_result_t r;
    int sx, sy, sz, idx;
    logic signed [VALUE_W-1:0] old;
    r = '0;
    if (a.mode == MODE_CLEAR) begin
      clear_grid_model();
      return r;
    end
    sx = grid_extent(cfg_model.size_x);
    sy = grid_extent(cfg_model.size_y);
    sz = grid_extent(cfg_model.size_z);
    // Only the linear index is range-checked, so a coordinate may spill into the next row
    idx = (int'(a.cx) + int'(cfg_model.offset_x))
        + (int'(a.cy) + int'(cfg_model.offset_y)) * sx
        + (int'(a.cz) + int'(cfg_model.offset_z)) * sx * sy;
    if (idx < 0 || idx >= sx * sy * sz) begin
      r.oor = 1'b1;
    end else begin
      old = grid_model[idx];
      r.read_value = old;
      if ((a.mode == MODE_WRITE_NEG && old < 0) || (a.mode == MODE_WRITE_POS && old > 0)) begin
        if (a.nv > 0 && old <= 0) above_zero_model++;
        if (a.nv <= 0 && old > 0) above_zero_model--;
        grid_model[idx] = a.nv;
        r.written = 1'b1;
      end
    end
    r.above_count = COUNT_OUT_W'(above_zero_model);
    return r;
  endfunction

  // Mostly aims inside the grid in use; otherwise any coordinate
  function automatic logic signed [COORD_W-1:0] pick_coord(int extent,
                                                           logic signed [COORD_W-1:0] off,
                                                           bit aimed);
    int c;
    if (!aimed || extent == 0) return COORD_W'($urandom);
    c = int'($urandom_range(0, extent - 1)) - int'(off);
    if (c < -128 || c > 127) return COORD_W'($urandom);
    return COORD_W'(c);
  endfunction

  function automatic access_t random_access();
    access_t a;
    int r;
    bit aimed;
    r = $urandom_range(0, 999);
    if (clears_left > 0 && r < 4) begin
      a.mode = MODE_CLEAR;
      clears_left--;
    end else if (r < 350) begin
      a.mode = MODE_WRITE_NEG;
    end else if (r < 700) begin
      a.mode = MODE_WRITE_POS;
    end else begin
      a.mode = MODE_READ;
    end
    aimed = ($urandom_range(0, 99) < 85);
    a.cx = pick_coord(grid_extent(cfg_model.size_x), cfg_model.offset_x, aimed);
    a.cy = pick_coord(grid_extent(cfg_model.size_y), cfg_model.offset_y, aimed);
    a.cz = pick_coord(grid_extent(cfg_model.size_z), cfg_model.offset_z, aimed);
    case ($urandom_range(0, 7))
      0: a.nv = '0;
      1: a.nv = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: a.nv = VALUE_W'($urandom);
    endcase
    return a;
  endfunction

  function automatic access_t mk(mode_e m, int x, int y, int z, int v);
    access_t a;
    a.mode = m;
    a.cx = COORD_W'(x);
    a.cy = COORD_W'(y);
    a.cz = COORD_W'(z);
    a.nv = VALUE_W'(v);
    return a;
  endfunction

  // Waits until every queued access has gone in and every result has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_accesses.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  // APB write: setup cycle, then access cycle held until pready
  task automatic write_reg(logic [2:0] idx, int val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OFFSET_X: cfg_model.offset_x = COORD_W'(val);
      REG_OFFSET_Y: cfg_model.offset_y = COORD_W'(val);
      REG_OFFSET_Z: cfg_model.offset_z = COORD_W'(val);
      REG_SIZE_X:   cfg_model.size_x   = SIZE_W'(val);
      REG_SIZE_Y:   cfg_model.size_y   = SIZE_W'(val);
      REG_SIZE_Z:   cfg_model.size_z   = SIZE_W'(val);
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Driver: presents queued accesses, holds a stalled transfer, idles at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(predict_access(on_bus));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus     <= pending_accesses.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation, stalls at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_value %0d count %0d", $time,
                   read_value_o, above_zero_count_o);
          mismatches++;
        end else begin
          access_result_t e;
          e = expected_results.pop_front();
          compare_field("read_value", int'(e.read_value), int'(read_value_o));
          compare_field("above_zero_count", int'(e.above_count), int'(above_zero_count_o));
          compare_field("written", int'(e.written), int'(written_o));
          compare_field("out_of_range", int'(e.oor), int'(out_of_range_o));
          n_results++;
          n_written += e.written;
          n_oor += e.oor;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int n_items;
    cfg_model.offset_x = '0;
    cfg_model.offset_y = '0;
    cfg_model.offset_z = '0;
    cfg_model.size_x   = SIZE_RESET;
    cfg_model.size_y   = SIZE_RESET;
    cfg_model.size_z   = SIZE_RESET;
    clear_grid_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset settings: full 32-cube, no offsets
    send_idle_pct = 21;
    recv_idle_pct = 47;
    @(negedge clk_i);
    pending_accesses.push_back(mk(MODE_READ,      0, 0, 0, 0));
    pending_accesses.push_back(mk(MODE_WRITE_POS, 0, 0, 0, 100));      // condition not met
    pending_accesses.push_back(mk(MODE_WRITE_NEG, 0, 0, 0, 32767));    // goes positive
    pending_accesses.push_back(mk(MODE_WRITE_POS, 0, 0, 0, -32768));   // back negative
    pending_accesses.push_back(mk(MODE_WRITE_NEG, 0, 0, 0, 0));        // to zero
    pending_accesses.push_back(mk(MODE_WRITE_NEG, 0, 0, 0, 5));        // zero is not negative
    pending_accesses.push_back(mk(MODE_WRITE_POS, 0, 0, 0, 5));        // nor positive
    pending_accesses.push_back(mk(MODE_READ,      31, 31, 31, 0));     // last entry
    pending_accesses.push_back(mk(MODE_WRITE_NEG, 31, 31, 31, 1));
    pending_accesses.push_back(mk(MODE_READ,      -128, -128, -128, 0));
    pending_accesses.push_back(mk(MODE_WRITE_NEG, 127, 127, 127, 77));
    pending_accesses.push_back(mk(MODE_READ,      32, 0, 0, 0));       // spills into next row
    pending_accesses.push_back(mk(MODE_READ,      -1, 1, 0, 0));       // negative spill
    pending_accesses.push_back(mk(MODE_READ,      0, 0, 32, 0));       // one past the end
    pending_accesses.push_back(mk(MODE_CLEAR,     127, -128, 5, 32767));
    pending_accesses.push_back(mk(MODE_READ,      31, 31, 31, 0));
    pending_accesses.push_back(mk(MODE_WRITE_NEG, 1, 2, 3, 4096));
    pending_accesses.push_back(mk(MODE_WRITE_NEG, 1, 2, 3, -1));
    pending_accesses.push_back(mk(MODE_WRITE_POS, 1, 2, 3, 2048));
    pending_accesses.push_back(mk(MODE_READ,      1, 2, 3, -1));
    wait_drained();

    // Random phases, one per register setting; idling pattern changes every third
    for (int s = 0; s < N_SETTINGS; s++) begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      write_reg(REG_OFFSET_X, set_ox[s]);
      write_reg(REG_OFFSET_Y, set_oy[s]);
      write_reg(REG_OFFSET_Z, set_oz[s]);
      write_reg(REG_SIZE_X,   set_sx[s]);
      write_reg(REG_SIZE_Y,   set_sy[s]);
      write_reg(REG_SIZE_Z,   set_sz[s]);
      if (s == N_SETTINGS - 1) begin
        // last setting: random offsets within reach of a small grid
        write_reg(REG_OFFSET_X, $urandom_range(0, 6) - 3);
        write_reg(REG_OFFSET_Y, $urandom_range(0, 6) - 3);
        write_reg(REG_OFFSET_Z, $urandom_range(0, 6) - 3);
      end
      send_idle_pct = (s < 3) ? 21 : (s < 6) ? 47 : 0;
      recv_idle_pct = (s < 3) ? 47 : (s < 6) ? 21 : 0;
      n_items = (set_sx[s] == 0 || set_sy[s] == 0 || set_sz[s] == 0) ? ITEMS_EMPTY
                                                                     : ITEMS_PER_SET;
      @(negedge clk_i);
      for (int i = 0; i < n_items; i++) pending_accesses.push_back(random_access());
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Checked %0d results over %0d register settings: %0d writes taken, %0d out of range",
             n_results, N_SETTINGS + 1, n_written, n_oor);
    $display("Clears issued in the random part: %0d", 8 - clears_left);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
